// ===== hdl/cpf_pkg.sv =====
// shared types and constants of the command packet framer
`default_nettype none
package cpf_pkg;

    // packet store depth, 20 to 31
    localparam int MAX_PACKET_BYTES = 20;
    localparam int FILL_W           = $clog2(MAX_PACKET_BYTES + 1);
    localparam int IDX_W            = $clog2(MAX_PACKET_BYTES);

    // packets that may wait between the framer and the output side
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // protocol characters
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_Q    = 8'h51;

    // fixed lengths per packet type
    localparam logic [FILL_W-1:0] LEN_GML = FILL_W'(15);
    localparam logic [FILL_W-1:0] LEN_Q   = FILL_W'(19);
    localparam logic [FILL_W-1:0] LEN_B   = FILL_W'(5);
    localparam logic [FILL_W-1:0] LEN_C   = FILL_W'(6);
    localparam logic [FILL_W-1:0] LEN_MAX = FILL_W'(MAX_PACKET_BYTES);

    // input operations
    localparam logic OP_BYTE = 1'b0;

    // one closed packet, handed from the framer to the output side
    typedef struct packed {
        logic [MAX_PACKET_BYTES-1:0][7:0] bytes;
        logic [FILL_W-1:0]                len;
        logic [7:0]                       ptype;
        logic                             ok;
        logic                             match;
    } pkt_t;

endpackage
`default_nettype wire

// ===== hdl/cpf_front.sv =====
// framer: accepts bytes and ticks, assembles packets, decides when to close
`default_nettype none
module cpf_front
    import cpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        q_full,
    output logic             q_push,
    output pkt_t             q_pkt
);

    logic [MAX_PACKET_BYTES-1:0][7:0] store_reg, store_next;
    logic [7:0]        last_reg, last_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        sum_reg, sum_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [15:0]       timeout_reg;

    logic              accept;
    logic              is_byte;
    logic              close;
    logic              complete;
    logic [FILL_W-1:0] base_idx;
    logic [7:0]        base_sum;
    logic [7:0]        kind;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_byte = (s_op == OP_BYTE);
    assign q_push  = accept && close;

    always_comb begin
        store_next = store_reg;
        last_next  = last_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        base_idx   = (s_byte_value == CH_BANG) ? '0 : fill_reg;
        base_sum   = (s_byte_value == CH_BANG) ? '0 : sum_reg;
        if (is_byte) begin
            fill_next = base_idx;
            sum_next  = base_sum;
            if (base_idx < LEN_MAX) begin
                store_next[base_idx[IDX_W-1:0]] = s_byte_value;
                last_next = s_byte_value;
                fill_next = base_idx + FILL_W'(1);
                sum_next  = base_sum + s_byte_value;
            end
        end

        // type-driven completion
        kind     = store_next[1];
        complete = 1'b0;
        if (fill_next >= LEN_MAX) begin
            complete = 1'b1;
        end else if (fill_next >= FILL_W'(2)) begin
            case (kind) inside
                CH_A:             complete = 1'b1;
                CH_G, CH_M, CH_L: complete = (fill_next == LEN_GML);
                CH_Q:             complete = (fill_next == LEN_Q);
                CH_B:             complete = (fill_next == LEN_B);
                CH_C:             complete = (fill_next == LEN_C);
                default:          complete = 1'b0;
            endcase
        end
        close = is_byte ? complete : (cnt_reg <= 16'd1);

        // descriptor of the closing packet
        q_pkt.bytes = store_next;
        q_pkt.len   = fill_next;
        q_pkt.ok    = (fill_next != '0) && (store_next[0] == CH_BANG);
        q_pkt.ptype = (q_pkt.ok && fill_next >= FILL_W'(2)) ? store_next[1] : 8'd0;
        q_pkt.match = q_pkt.ok && (~(sum_next - last_next) == last_next);

        cnt_next = cnt_reg;
        if (close || is_byte) begin
            cnt_next = timeout_reg;
        end else begin
            cnt_next = cnt_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            store_reg <= store_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            fill_reg    <= '0;
            sum_reg     <= '0;
            cnt_reg     <= TIMEOUT_RESET;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (accept) begin
                cnt_reg <= cnt_next;
                if (close) begin
                    fill_reg <= '0;
                    sum_reg  <= '0;
                end else begin
                    fill_reg <= fill_next;
                    sum_reg  <= sum_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cpf_queue.sv =====
// short fifo of closed packets between framer and output side
`default_nettype none
module cpf_queue
    import cpf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  pkt_t      push_pkt,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output pkt_t      head_pkt
);

    pkt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cpf_back.sv =====
// output side: plays one queued packet out as a run of results
`default_nettype none
module cpf_back
    import cpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  pkt_t             head_pkt,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_last,
    output logic             m_packet_ok,
    output logic [4:0]       m_packet_length,
    output logic [7:0]       m_packet_type,
    output logic             m_checksum_match
);

    logic [IDX_W-1:0] k_reg;
    logic             valid_reg;
    logic [7:0]       data_reg;
    logic             last_reg;
    logic             ok_reg;
    logic [4:0]       len_reg;
    logic [7:0]       type_reg;
    logic             match_reg;

    logic             load;
    logic             at_end;

    assign load   = head_valid && (!valid_reg || m_ready);
    assign at_end = !head_pkt.ok
                    || ((FILL_W'(k_reg) + FILL_W'(1)) == head_pkt.len);
    assign q_pop  = load && at_end;

    assign m_valid          = valid_reg;
    assign m_data_byte      = data_reg;
    assign m_last           = last_reg;
    assign m_packet_ok      = ok_reg;
    assign m_packet_length  = len_reg;
    assign m_packet_type    = type_reg;
    assign m_checksum_match = match_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg  <= head_pkt.ok ? head_pkt.bytes[k_reg] : 8'd0;
            last_reg  <= at_end;
            ok_reg    <= head_pkt.ok;
            len_reg   <= head_pkt.ok ? head_pkt.len[4:0] : 5'd0;
            type_reg  <= head_pkt.ok ? head_pkt.ptype : 8'd0;
            match_reg <= head_pkt.ok && head_pkt.match;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                k_reg     <= at_end ? '0 : k_reg + IDX_W'(1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // retiring a packet always leaves its final result on the output
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (valid_reg && last_reg))
        else $error("packet retired without a final result");

    // a failure result is a single zeroed result
    a_fail_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !ok_reg) |-> (last_reg && len_reg == 5'd0 && data_reg == 8'd0))
        else $error("failure result not a single zeroed result");

    // run index stays inside the packet store
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg < IDX_W'(MAX_PACKET_BYTES))
        else $error("run index beyond packet store");

endmodule
`default_nettype wire

// ===== hdl/command_packet_framer.sv =====
// top level of the command packet framer: framer, packet queue, output side
// first result, queue empty: the closing packet is registered in the packet queue, then in the output registers
// throughput: one byte or tick per cycle while the packet queue has room (2 packets)
// a packet of n bytes drains as n results, one result per cycle while m_ready is high; a failure is one result
// input stalls only when the packet queue is full behind a draining run
// reset (aresetn, synchronous, low): empty packet, idle count and timeout back to 1000
`default_nettype none
module command_packet_framer
    import cpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // timeout register write
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // byte and tick transfers
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_byte_value,
    // result transfers
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_last,
    output logic             m_packet_ok,
    output logic [4:0]       m_packet_length,
    output logic [7:0]       m_packet_type,
    output logic             m_checksum_match
);

    // framer to queue
    logic q_push;
    logic q_full;
    pkt_t q_pkt;

    // queue to output side
    logic q_pop;
    logic head_valid;
    pkt_t head_pkt;

    // framer: stores bytes, keeps sum and idle count, closes packets
    cpf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_byte_value (s_byte_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_pkt        (q_pkt)
    );

    // closed packets wait here so framing goes on during a run
    cpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_pkt   (q_pkt),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_pkt   (head_pkt)
    );

    // registered output, one result per transfer
    cpf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_pkt         (head_pkt),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_last           (m_last),
        .m_packet_ok      (m_packet_ok),
        .m_packet_length  (m_packet_length),
        .m_packet_type    (m_packet_type),
        .m_checksum_match (m_checksum_match)
    );

endmodule
`default_nettype wire

// ===== tb/command_packet_framer_tb.sv =====
`timescale 1ns / 100ps
// testbench for the command packet framer: predicted packet runs checked result by result
module command_packet_framer_tb;
    import cpf_pkg::*;

    // tick transfers carry the other op code
    localparam logic OP_TICK = 1'b1;
    // items per random phase
    localparam int PHASE_ITEMS = 80;
    // cycles allowed for the block to settle after the last expected result
    localparam int SETTLE_CYCLES = 8;

    // one result transfer as the block should present it
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       ok;
        logic [4:0] length;
        logic [7:0] ptype;
        logic       cksum_ok;
    } framed_result_t;

    // packet framing predictor plus the queue of results still owed by the block
    class framer_scoreboard;
        framed_result_t expected_q[$];
        logic [15:0]    timeout_ticks;
        logic [7:0]     held[MAX_PACKET_BYTES];
        int             fill_count;
        int             idle_left;
        logic [7:0]     byte_sum;
        int             packets_framed;
        int             failures;
        int             cksum_hits;
        int             results_checked;
        int             mismatches;

        function new();
            timeout_ticks   = TIMEOUT_RESET;
            packets_framed  = 0;
            failures        = 0;
            cksum_hits      = 0;
            results_checked = 0;
            mismatches      = 0;
            foreach (held[k]) held[k] = 8'h00;
            rearm();
        endfunction

        function void rearm();
            fill_count = 0;
            byte_sum   = 8'h00;
            idle_left  = timeout_ticks;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_ticks = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // queue the run for the open packet, or one failure result
        function void close_packet();
            framed_result_t r;
            logic [7:0]     final_byte;
            logic [7:0]     check;
            r = '0;
            if (fill_count == 0 || held[0] != CH_BANG) begin
                r.last = 1'b1;
                expected_q.push_back(r);
                failures++;
            end else begin
                final_byte = held[fill_count - 1];
                check      = ~(byte_sum - final_byte);
                r.ok       = 1'b1;
                r.length   = 5'(fill_count);
                r.ptype    = (fill_count >= 2) ? held[1] : 8'h00;
                r.cksum_ok = (check == final_byte);
                for (int k = 0; k < fill_count; k++) begin
                    r.data_byte = held[k];
                    r.last      = (k == fill_count - 1);
                    expected_q.push_back(r);
                end
                packets_framed++;
                if (r.cksum_ok) cksum_hits++;
            end
            rearm();
        endfunction

        // one accepted byte or tick
        function void take_transfer(logic op, logic [7:0] value);
            bit done;
            done = 1'b0;
            if (op == OP_BYTE) begin
                if (value == CH_BANG) begin
                    fill_count = 0;
                    byte_sum   = 8'h00;
                end
                if (fill_count < MAX_PACKET_BYTES) begin
                    held[fill_count] = value;
                    fill_count++;
                    byte_sum += value;
                end
                idle_left = timeout_ticks;
                if (fill_count >= MAX_PACKET_BYTES) begin
                    done = 1'b1;
                end else if (fill_count >= 2) begin
                    case (held[1])
                        CH_A:             done = 1'b1;
                        CH_G, CH_M, CH_L: done = (fill_count == LEN_GML);
                        CH_Q:             done = (fill_count == LEN_Q);
                        CH_B:             done = (fill_count == LEN_B);
                        CH_C:             done = (fill_count == LEN_C);
                        default:          done = 1'b0;
                    endcase
                end
                if (done) close_packet();
            end else if (idle_left <= 1) begin
                close_packet();
            end else begin
                idle_left--;
            end
        endfunction

        function void check_result(logic [7:0] data_byte, logic last, logic ok,
                                   logic [4:0] length, logic [7:0] ptype, logic cksum_ok);
            framed_result_t got;
            framed_result_t want;
            got = '{data_byte, last, ok, length, ptype, cksum_ok};
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected result byte %h last %b ok %b len %0d type %h cksum %b",
                             $realtime, data_byte, last, ok, length, ptype, cksum_ok);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%t: result mismatch", $realtime);
                    $display("  expected byte %h last %b ok %b len %0d type %h cksum %b",
                             want.data_byte, want.last, want.ok, want.length, want.ptype,
                             want.cksum_ok);
                    $display("  actual   byte %h last %b ok %b len %0d type %h cksum %b",
                             got.data_byte, got.last, got.ok, got.length, got.ptype,
                             got.cksum_ok);
                end
            end
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic [15:0] cfg_wr_data      = 16'd0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_op             = OP_BYTE;
    logic [7:0]  s_byte_value     = 8'h00;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_data_byte;
    logic        m_last;
    logic        m_packet_ok;
    logic [4:0]  m_packet_length;
    logic [7:0]  m_packet_type;
    logic        m_checksum_match;

    framer_scoreboard framer_sb;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               items_sent  = 0;
    logic [15:0]      timeout_now = TIMEOUT_RESET;
    int               errors;

    command_packet_framer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_byte_value     (s_byte_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_last           (m_last),
        .m_packet_ok      (m_packet_ok),
        .m_packet_length  (m_packet_length),
        .m_packet_type    (m_packet_type),
        .m_checksum_match (m_checksum_match)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: check each transfer, then pick ready for the next cycle
    // values seen here are the ones from before the edge, so no race with the block
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            framer_sb.check_result(m_data_byte, m_last, m_packet_ok, m_packet_length,
                                   m_packet_type, m_checksum_match);
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one byte or tick transfer, after a random gap on the sender side
    task automatic send_item(input logic op, input logic [7:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            // valid drops only when a gap follows, so it is never lowered and raised in one step
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_byte_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        framer_sb.take_transfer(op, value);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_item(OP_BYTE, value);
    endtask

    // the byte lane carries junk on ticks, the block has to ignore it
    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom));
    endtask

    // enough ticks to expire the idle count when the timeout is short
    task automatic send_expiry_ticks();
        int n;
        n = (timeout_now <= 16) ? ((timeout_now == 0) ? 1 : int'(timeout_now))
                                : $urandom_range(1, 3);
        repeat (n) send_tick();
    endtask

    // hold the sender off until every owed result has come out and the block settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (framer_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        framer_sb.set_timeout(value);
        timeout_now = value;
    endtask

    // one random sequence: mostly packets with random content, some noise and truncation
    task automatic send_random_sequence();
        int         pick;
        int         len;
        int         n;
        logic [7:0] kind;
        logic [7:0] b;
        logic [7:0] sum;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise without a leading bang, or nothing at all before the ticks
            n = $urandom_range(0, 4);
            repeat (n) begin
                do b = 8'($urandom); while (b == CH_BANG);
                send_byte(b);
            end
            if (n == 0 || $urandom_range(1)) send_expiry_ticks();
            return;
        end
        pick = $urandom_range(99);
        if (pick < 18)      kind = CH_A;
        else if (pick < 36) kind = CH_B;
        else if (pick < 54) kind = CH_C;
        else if (pick < 60) kind = CH_G;
        else if (pick < 66) kind = CH_M;
        else if (pick < 72) kind = CH_L;
        else if (pick < 80) kind = CH_Q;
        else                kind = 8'($urandom);
        case (kind)
            CH_A:             len = 2;
            CH_B:             len = LEN_B;
            CH_C:             len = LEN_C;
            CH_G, CH_M, CH_L: len = LEN_GML;
            CH_Q:             len = LEN_Q;
            default:          len = MAX_PACKET_BYTES;
        endcase
        // some packets stop short and are left to the idle timeout
        n = ($urandom_range(99) < 15) ? $urandom_range(1, len - 1) : len;
        send_byte(CH_BANG);
        sum = CH_BANG;
        if (n >= 2) begin
            send_byte(kind);
            sum += kind;
        end
        for (int k = 2; k < n; k++) begin
            // half the full packets of three or more bytes end on a good checksum
            if (k == len - 1 && $urandom_range(1))
                b = ~sum;
            else
                do b = 8'($urandom); while (b == CH_BANG && $urandom_range(9) != 0);
            if ($urandom_range(99) < 6) send_tick();
            send_byte(b);
            sum += b;
        end
        if (n < len) send_expiry_ticks();
    endtask

    task automatic run_random_phase(input logic [15:0] timeout, input int tx_pct,
                                    input int rx_pct);
        int target;
        write_timeout(timeout);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = items_sent + PHASE_ITEMS;
        while (items_sent < target) send_random_sequence();
    endtask

    initial begin
        framer_sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 9;
        rx_idle_pct = 64;

        // short timeout for the directed part
        write_timeout(16'd3);
        // ticks with nothing held; the idle count is still at its reset value, so none expire
        repeat (3) send_tick();
        // packet not starting with a bang, closed by the timeout
        send_byte(8'hFF);
        repeat (3) send_tick();
        // type A closes as soon as the type byte is in
        send_byte(CH_BANG);
        send_byte(CH_A);
        // type B with byte extremes and a matching checksum byte
        send_byte(CH_BANG);
        send_byte(CH_B);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h9D);
        // bang inside a packet restarts it, the earlier Q type no longer counts
        send_byte(CH_BANG);
        send_byte(CH_Q);
        send_byte(CH_BANG);
        send_byte(CH_C);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'h55);

        // timeout of zero closes on every tick once the idle count has been reloaded
        write_timeout(16'd0);
        send_tick();
        // a lone bang makes a one byte packet with no type
        send_byte(CH_BANG);
        send_tick();

        // random traffic over several timeouts and idling patterns
        run_random_phase(16'd6, 9, 64);
        run_random_phase(16'hFFFF, 64, 9);
        run_random_phase(16'd1, 0, 0);
        run_random_phase(16'($urandom_range(2, 10)), 0, 0);

        wait_idle();
        errors = framer_sb.mismatches + framer_sb.pending();
        $display("%0d input transfers, %0d result transfers checked, %0d mismatches",
                 items_sent, framer_sb.results_checked, framer_sb.mismatches);
        $display("%0d packets framed (%0d with good checksum), %0d failed packets",
                 framer_sb.packets_framed, framer_sb.cksum_hits, framer_sb.failures);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("%t: run stopped by watchdog", $realtime);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
